FILE: src/biou_pkg.sv
// ----------------------------------------------------------------------------
// biou_pkg
// Shared types and constants for the box IoU pipeline.
// ----------------------------------------------------------------------------
package biou_pkg;

    localparam int COORD_BITS    = 16;
    localparam int IOU_FRAC_BITS = 16;
    localparam int AREA_BITS     = 2 * COORD_BITS;
    localparam int REM_BITS      = AREA_BITS + 1;
    localparam int Q_BITS        = IOU_FRAC_BITS + 1;
    localparam int NUM_CELLS     = Q_BITS;

    localparam logic [Q_BITS-1:0] IOU_ONE = {1'b1, {IOU_FRAC_BITS{1'b0}}};

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [AREA_BITS-1:0]  area_t;

    typedef struct packed {
        coord_t a_x1;
        coord_t a_y1;
        coord_t a_x2;
        coord_t a_y2;
        coord_t b_x1;
        coord_t b_y1;
        coord_t b_x2;
        coord_t b_y2;
    } in_t;

    typedef struct packed {
        logic [Q_BITS-1:0] iou;
        logic              overlaps;
    } out_t;

    // word handed from cell to cell of the divider chain
    typedef struct packed {
        logic                overlaps;
        area_t               den;
        logic [REM_BITS-1:0] p;
        logic [Q_BITS-1:0]   q;
    } div_t;

endpackage

FILE: src/box_iou_top.sv
// ----------------------------------------------------------------------------
// box_iou_top
// Intersection over union of two boxes, one pair per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  | signals                        | word
//  ---------+--------------------------------+---------------------------
//  input    | in_valid / in_ready / in_word  | biou_pkg::in_t  (8 corners)
//  output   | out_valid / out_ready / out_word | biou_pkg::out_t (iou, flag)
//
// Accepts one box pair per cycle unless the output stalls. Three front stages
// (corners, products, union) precede one divider cell per quotient bit (17).
// Every stage has its own valid bit, so bubbles close up while the output
// is stalled and the pipeline keeps taking words until all stages are full.
// Reset clears the valid bits only; the data registers are not reset.
module box_iou_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  biou_pkg::in_t  in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output biou_pkg::out_t out_word
);
    import biou_pkg::*;

    logic [NUM_CELLS:0] chain_valid;
    logic [NUM_CELLS:0] chain_ready;
    div_t               chain_word [NUM_CELLS+1];

    biou_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_word  (chain_word[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        biou_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    assign chain_ready[NUM_CELLS] = out_ready;
    assign out_valid              = chain_valid[NUM_CELLS];
    assign out_word.iou           = chain_word[NUM_CELLS].q;
    assign out_word.overlaps      = chain_word[NUM_CELLS].overlaps;

    a_iou_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.iou <= IOU_ONE)
        else $error("iou above one");
    a_no_overlap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.overlaps |-> out_word.iou == '0)
        else $error("nonzero iou without overlap");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

endmodule

FILE: src/biou_front.sv
// ----------------------------------------------------------------------------
// biou_front
// Intersection corners, areas and union in three register stages.
// ----------------------------------------------------------------------------
module biou_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  biou_pkg::in_t in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output biou_pkg::div_t out_word
);
    import biou_pkg::*;

    logic   s1_valid_reg, s1_valid_next;
    logic   s1_ovl_reg;
    coord_t s1_iw_reg, s1_ih_reg, s1_aw_reg, s1_ah_reg, s1_bw_reg, s1_bh_reg;
    logic   s2_valid_reg, s2_valid_next;
    logic   s2_ovl_reg;
    area_t  s2_inter_reg, s2_area_a_reg, s2_area_b_reg;
    logic   s3_valid_reg, s3_valid_next;
    div_t   s3_word_reg;

    logic   s1_ready, s2_ready, s3_ready;
    coord_t ix1, iy1, ix2, iy2;
    area_t  uni;
    div_t   s3_word_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        ix1 = (in_word.a_x1 > in_word.b_x1) ? in_word.a_x1 : in_word.b_x1;
        iy1 = (in_word.a_y1 > in_word.b_y1) ? in_word.a_y1 : in_word.b_y1;
        ix2 = (in_word.a_x2 < in_word.b_x2) ? in_word.a_x2 : in_word.b_x2;
        iy2 = (in_word.a_y2 < in_word.b_y2) ? in_word.a_y2 : in_word.b_y2;
    end

    // union never exceeds the bounding box, so it fits the area width
    assign uni = s2_area_a_reg - s2_inter_reg + s2_area_b_reg;

    always_comb
    begin
        s3_word_next.overlaps = s2_ovl_reg;
        s3_word_next.q        = '0;
        if (s2_ovl_reg)
        begin
            s3_word_next.den = uni;
            s3_word_next.p   = {1'b0, s2_inter_reg};
        end
        else
        begin
            // empty box: divide zero by one to get a zero quotient
            s3_word_next.den = area_t'(1);
            s3_word_next.p   = '0;
        end
    end

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_ovl_reg <= (ix2 > ix1) && (iy2 > iy1);
            s1_iw_reg  <= ix2 - ix1;
            s1_ih_reg  <= iy2 - iy1;
            s1_aw_reg  <= in_word.a_x2 - in_word.a_x1;
            s1_ah_reg  <= in_word.a_y2 - in_word.a_y1;
            s1_bw_reg  <= in_word.b_x2 - in_word.b_x1;
            s1_bh_reg  <= in_word.b_y2 - in_word.b_y1;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_ovl_reg    <= s1_ovl_reg;
            s2_inter_reg  <= area_t'(s1_iw_reg) * area_t'(s1_ih_reg);
            s2_area_a_reg <= area_t'(s1_aw_reg) * area_t'(s1_ah_reg);
            s2_area_b_reg <= area_t'(s1_bw_reg) * area_t'(s1_bh_reg);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_word_reg <= s3_word_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_word  = s3_word_reg;

    a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_word_reg.p <= {1'b0, s3_word_reg.den})
        else $error("numerator exceeds union");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_word_reg.den != '0)
        else $error("zero divisor");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_word_reg.overlaps |-> s3_word_reg.p == '0)
        else $error("empty box with nonzero numerator");

endmodule

FILE: src/biou_div_cell.sv
// ----------------------------------------------------------------------------
// biou_div_cell
// One restoring division step: compare, subtract, shift, one quotient bit.
// ----------------------------------------------------------------------------
module biou_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  biou_pkg::div_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output biou_pkg::div_t out_word
);
    import biou_pkg::*;

    logic                valid_reg, valid_next;
    div_t                word_reg, word_next;
    logic                take;
    logic [REM_BITS-1:0] den_ext;
    logic [REM_BITS-1:0] rem;

    assign in_ready = !valid_reg || out_ready;
    assign den_ext  = {1'b0, in_word.den};
    assign take     = in_word.p >= den_ext;
    assign rem      = take ? (in_word.p - den_ext) : in_word.p;

    always_comb
    begin
        word_next.overlaps = in_word.overlaps;
        word_next.den      = in_word.den;
        // remainder is below den, so the shifted value still fits
        word_next.p        = {rem[REM_BITS-2:0], 1'b0};
        word_next.q        = {in_word.q[Q_BITS-2:0], take};
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> word_reg.p < {word_reg.den, 1'b0})
        else $error("partial remainder out of range");
    a_take_fits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> in_word.p < {in_word.den, 1'b0})
        else $error("step input remainder out of range");

endmodule

FILE: sim/box_iou_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_iou_tb
// Self-checking bench for the box IoU pipeline.
// A short table of box pairs goes in first: extremes, shared edges, inverted
// and zero-width boxes, identical boxes. Random pairs follow, most of them
// overlapping. Each result is compared in order with the expected word: a
// fixed value for some table rows, an in-bench IoU calculation otherwise. The
// sender goes in bursts, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;

    import biou_pkg::*;

    localparam int N_RANDOM    = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 200;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    localparam out_t NO_HIT   = '{iou: '0, overlaps: 1'b0};
    localparam out_t FULL_HIT = '{iou: IOU_ONE, overlaps: 1'b1};

    typedef struct {
        in_t  word;
        bit   fixed;
        out_t want;
    } pair_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_word;
    logic out_valid;
    logic out_ready;
    out_t out_word;

    out_t      iou_q[$];
    pair_row_t pair_rows[$];
    int        errors;
    int        cycles;
    int        burst_left;

    box_iou_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact IoU of one box pair, truncated to Q1.16.
    function automatic out_t calc_iou(input in_t w);
        longint unsigned ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        longint unsigned lo_x, lo_y, hi_x, hi_y;
        longint unsigned ovl, area_a, area_b, uni;
        out_t r;
        ax1 = w.a_x1; ay1 = w.a_y1; ax2 = w.a_x2; ay2 = w.a_y2;
        bx1 = w.b_x1; by1 = w.b_y1; bx2 = w.b_x2; by2 = w.b_y2;
        lo_x = (ax1 > bx1) ? ax1 : bx1;
        lo_y = (ay1 > by1) ? ay1 : by1;
        hi_x = (ax2 < bx2) ? ax2 : bx2;
        hi_y = (ay2 < by2) ? ay2 : by2;
        r = NO_HIT;
        if (hi_x > lo_x && hi_y > lo_y) begin
            ovl    = (hi_x - lo_x) * (hi_y - lo_y);
            area_a = (ax2 - ax1) * (ay2 - ay1);
            area_b = (bx2 - bx1) * (by2 - by1);
            uni    = (area_a - ovl) + area_b;
            r.iou      = Q_BITS'((ovl << IOU_FRAC_BITS) / uni);
            r.overlaps = 1'b1;
        end
        return r;
    endfunction

    function automatic in_t box_pair(input coord_t ax1, input coord_t ay1,
                                     input coord_t ax2, input coord_t ay2,
                                     input coord_t bx1, input coord_t by1,
                                     input coord_t bx2, input coord_t by2);
        in_t w;
        w = '{ax1, ay1, ax2, ay2, bx1, by1, bx2, by2};
        return w;
    endfunction

    function automatic void add_row(input in_t w, input bit fixed, input out_t want);
        pair_row_t row;
        row.word  = w;
        row.fixed = fixed;
        row.want  = want;
        pair_rows.push_back(row);
    endfunction

    // One edge pair of random length, at most lim wide.
    function automatic void rand_span(input int lim, output int lo, output int hi);
        int len;
        len = $urandom_range(1, lim);
        lo  = $urandom_range(0, COORD_MAX - len);
        hi  = lo + len;
    endfunction

    // An edge pair placed near [lo, hi) so that the two often overlap.
    function automatic void near_span(input int lo, input int hi,
                                      output int nlo, output int nhi);
        int len, off, nlen;
        len  = hi - lo;
        off  = int'($urandom_range(0, 2 * len)) - len;
        nlen = $urandom_range(1, 2 * len);
        nlo  = lo + off;
        if (nlo < 0)
            nlo = 0;
        if (nlo > COORD_MAX - 1)
            nlo = COORD_MAX - 1;
        nhi = nlo + nlen;
        if (nhi > COORD_MAX)
            nhi = COORD_MAX;
    endfunction

    function automatic in_t rand_pair();
        in_t w;
        int kind, lim, t;
        int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        kind = $urandom_range(0, 9);
        // noise: every bit free, mostly inverted or disjoint boxes
        if (kind < 2) begin
            w = {$urandom, $urandom, $urandom, $urandom};
            return w;
        end
        lim = (1 << $urandom_range(1, COORD_BITS)) - 1;
        rand_span(lim, ax1, ax2);
        rand_span(lim, ay1, ay2);
        if (kind == 3) begin
            bx1 = ax1; bx2 = ax2; by1 = ay1; by2 = ay2;
        end
        else begin
            near_span(ax1, ax2, bx1, bx2);
            near_span(ay1, ay2, by1, by2);
        end
        // broken pair: flip one box along one axis
        if (kind == 2) begin
            case ($urandom_range(0, 3))
                0: begin t = ax1; ax1 = ax2; ax2 = t; end
                1: begin t = ay1; ay1 = ay2; ay2 = t; end
                2: begin t = bx1; bx1 = bx2; bx2 = t; end
                default: begin t = by1; by1 = by2; by2 = t; end
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            w = box_pair(coord_t'(bx1), coord_t'(by1), coord_t'(bx2), coord_t'(by2),
                         coord_t'(ax1), coord_t'(ay1), coord_t'(ax2), coord_t'(ay2));
        else
            w = box_pair(coord_t'(ax1), coord_t'(ay1), coord_t'(ax2), coord_t'(ay2),
                         coord_t'(bx1), coord_t'(by1), coord_t'(bx2), coord_t'(by2));
        return w;
    endfunction

    task automatic send_word(input in_t w, input out_t want);
        int gap;
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        iou_q.push_back(want);
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 40);
        end
    endtask

    initial begin : run
        in_t w;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        errors     = 0;
        burst_left = 0;

        add_row(box_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, NO_HIT);
        add_row(box_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1, NO_HIT);
        add_row(box_pair(0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF), 1, FULL_HIT);
        add_row(box_pair(1, 1, 2, 2, 1, 1, 2, 2), 1, FULL_HIT);
        add_row(box_pair(0, 0, 10, 10, 20, 0, 30, 10), 1, NO_HIT);
        add_row(box_pair(0, 0, 10, 10, 0, 20, 10, 30), 1, NO_HIT);
        // boxes that only share an edge
        add_row(box_pair(0, 0, 16, 16, 16, 0, 32, 16), 1, NO_HIT);
        add_row(box_pair(0, 0, 16, 16, 0, 16, 16, 32), 1, NO_HIT);
        // inverted boxes
        add_row(box_pair(32, 0, 0, 32, 0, 0, 32, 32), 1, NO_HIT);
        add_row(box_pair(0, 0, 32, 32, 0, 32, 32, 0), 1, NO_HIT);
        add_row(box_pair(16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF), 1, NO_HIT);
        // zero-width box
        add_row(box_pair(5, 0, 5, 9, 0, 0, 9, 9), 1, NO_HIT);
        add_row(box_pair(0, 0, 64, 64, 16, 16, 32, 32), 0, NO_HIT);
        add_row(box_pair(16, 16, 32, 32, 0, 0, 64, 64), 0, NO_HIT);
        add_row(box_pair(0, 0, 32, 32, 16, 0, 48, 32), 0, NO_HIT);
        add_row(box_pair(0, 0, 2, 1, 1, 0, 3, 1), 0, NO_HIT);
        add_row(box_pair(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF),
                0, NO_HIT);
        add_row(box_pair(0, 0, 16'hFFFF, 16'hFFFF, 1, 0, 16'hFFFF, 16'hFFFF), 0, NO_HIT);
        add_row(box_pair(0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 1, 1), 0, NO_HIT);
        add_row(box_pair(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 0, 0, 16'h8001, 16'h8001),
                0, NO_HIT);
        add_row(box_pair(16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF,
                         16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF), 0, NO_HIT);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pair_rows[i])
            send_word(pair_rows[i].word,
                      pair_rows[i].fixed ? pair_rows[i].want : calc_iou(pair_rows[i].word));

        repeat (N_RANDOM) begin
            w = rand_pair();
            send_word(w, calc_iou(w));
        end
        in_valid <= 1'b0;

        while (iou_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("PASS box_iou_top");
        else
            $display("FAIL box_iou_top");
        $finish;
    end

    // Receiver: each stretch picks its own stall pattern.
    initial begin : rx_stall
        int mode, span;
        out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(20, 300);
            for (int k = 0; k < span; k++) begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    3: out_ready <= (k % 7 != 0);
                    default: out_ready <= (k % 32 == 31);
                endcase
            end
        end
    end

    always @(posedge clk) begin : check_out
        out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (iou_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word iou=%0d overlaps=%0b",
                             $time, out_word.iou, out_word.overlaps);
            end
            else begin
                want = iou_q.pop_front();
                if (out_word.iou !== want.iou) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: iou expected %0d, got %0d",
                                 $time, want.iou, out_word.iou);
                end
                if (out_word.overlaps !== want.overlaps) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: overlaps expected %0b, got %0b",
                                 $time, want.overlaps, out_word.overlaps);
                end
            end
        end
    end

    initial cycles = 0;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout at %0t, %0d words still expected", $time, iou_q.size());
            $display("FAIL box_iou_top");
            $finish;
        end
    end

endmodule
